/* design/bfd_pkg.sv */
// bfd_pkg: types and constants shared by the binary field decoder
// holds the mode codes, decoder state and result structs
// no dependencies
package bfd_pkg;

    typedef enum logic [3:0] {
        MODE_U8   = 4'd0,
        MODE_U16  = 4'd1,
        MODE_U32  = 4'd2,
        MODE_U64  = 4'd3,
        MODE_I8   = 4'd4,
        MODE_I32  = 4'd5,
        MODE_I64  = 4'd6,
        MODE_VU32 = 4'd7,
        MODE_VU64 = 4'd8,
        MODE_VI32 = 4'd9,
        MODE_VI64 = 4'd10
    } mode_t;

    localparam int unsigned CONT_BIT = 7;
    localparam int unsigned SIGN_BIT = 6;
    localparam logic [3:0]  LIMIT64  = 4'd10;
    localparam logic [3:0]  LIMIT32  = 4'd5;

    typedef struct packed {
        logic [63:0] acc;
        logic [3:0]  cnt;
        mode_t       mode;
        logic        busy;
    } dec_state_t;

    typedef struct packed {
        logic [63:0] value;
        logic        status;
        logic [3:0]  bytes_used;
    } dec_result_t;

endpackage

/* design/binary_field_decoder.sv */
// binary_field_decoder: byte-serial little-endian and LEB128 varint decoder
// output: each result is registered on the transfer of its final byte and shown in the next cycle
// throughput: one byte per cycle unless a held result stalls s_ready, set by the single decode step per byte
// reset: aresetn synchronous active low, clears the value in progress and m_valid
// depends on bfd_pkg and bfd_step
module binary_field_decoder
    import bfd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic [3:0]  s_mode,
    input  logic        s_buffer_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_value,
    output logic        m_status,
    output logic [3:0]  m_bytes_used
);

    dec_state_t  st_reg;
    dec_state_t  st_next;
    dec_result_t result_reg;
    dec_result_t result_next;
    logic        m_valid_reg;
    logic        emit;
    logic        s_xfer;

    bfd_step u_step (
        .state_cur  (st_reg),
        .data_byte  (s_data_byte),
        .mode_in    (s_mode),
        .buffer_end (s_buffer_end),
        .state_next (st_next),
        .emit       (emit),
        .result     (result_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign s_xfer  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                st_reg <= st_next;
            end
            if (s_xfer && emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result payload, no reset
    always_ff @(posedge aclk) begin
        if (s_xfer && emit) begin
            result_reg <= result_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_value      = result_reg.value;
    assign m_status     = result_reg.status;
    assign m_bytes_used = result_reg.bytes_used;

endmodule

/* design/bfd_step.sv */
// bfd_step: per-byte decode logic, next state and result for one byte
// depends on bfd_pkg
module bfd_step
    import bfd_pkg::*;
(
    input  dec_state_t  state_cur,
    input  logic [7:0]  data_byte,
    input  logic [3:0]  mode_in,
    input  logic        buffer_end,
    output dec_state_t  state_next,
    output logic        emit,
    output dec_result_t result
);

    mode_t       mode_new;
    mode_t       m;
    logic [63:0] acc_b;
    logic [3:0]  cnt_b;
    logic [3:0]  cnt_n;
    logic        is_var;
    logic        is32;
    logic        sgn;
    logic [3:0]  width;
    logic        sext8;
    logic        sext32;
    logic [6:0]  vsh;
    logic [6:0]  esh;
    logic [5:0]  fsh;
    logic [63:0] acc_var;
    logic [63:0] acc_fix;
    logic [63:0] v;
    logic        done;
    logic        fail;
    logic [3:0]  limit;

    always_comb begin
        mode_new = (mode_in > 4'(MODE_VI64)) ? MODE_U8 : mode_t'(mode_in);
        m        = state_cur.busy ? state_cur.mode : mode_new;
        acc_b    = state_cur.busy ? state_cur.acc : 64'd0;
        cnt_b    = state_cur.busy ? state_cur.cnt : 4'd0;
        cnt_n    = cnt_b + 4'd1;

        is_var = 1'b0;
        is32   = 1'b0;
        sgn    = 1'b0;
        width  = 4'd1;
        sext8  = 1'b0;
        sext32 = 1'b0;
        unique case (m)
            MODE_U16:  width = 4'd2;
            MODE_U32:  width = 4'd4;
            MODE_U64:  width = 4'd8;
            MODE_I8:   sext8 = 1'b1;
            MODE_I32: begin
                width  = 4'd4;
                sext32 = 1'b1;
            end
            MODE_I64:  width = 4'd8;
            MODE_VU32: begin
                is_var = 1'b1;
                is32   = 1'b1;
            end
            MODE_VU64: is_var = 1'b1;
            MODE_VI32: begin
                is_var = 1'b1;
                is32   = 1'b1;
                sgn    = 1'b1;
            end
            MODE_VI64: begin
                is_var = 1'b1;
                sgn    = 1'b1;
            end
            default: width = 4'd1;
        endcase
        limit = is32 ? LIMIT32 : LIMIT64;

        // varint: 7 payload bits per byte
        vsh     = 7'(cnt_b) * 7'd7;
        acc_var = acc_b;
        if (vsh < 7'd64) begin
            acc_var = acc_b | ({57'd0, data_byte[6:0]} << vsh[5:0]);
        end
        // fixed width: little endian bytes
        fsh     = {cnt_b[2:0], 3'b000};
        acc_fix = acc_b | ({56'd0, data_byte} << fsh);

        esh = 7'(cnt_n) * 7'd7;
        if (is_var) begin
            done = !data_byte[CONT_BIT];
            fail = (cnt_n >= limit) || buffer_end;
            v    = acc_var;
            if (sgn && (esh < 7'd64) && data_byte[SIGN_BIT]) begin
                v = v | ({64{1'b1}} << esh[5:0]);
            end
            if (is32) begin
                v = sgn ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
            end
        end else begin
            done = (cnt_n >= width);
            fail = buffer_end;
            v    = acc_fix;
            if (sext8) begin
                v = {{56{v[7]}}, v[7:0]};
            end else if (sext32) begin
                v = {{32{v[31]}}, v[31:0]};
            end
        end

        emit              = done || fail;
        result.value      = done ? v : 64'd0;
        result.status     = !done;
        result.bytes_used = cnt_n;

        state_next.acc  = is_var ? acc_var : acc_fix;
        state_next.cnt  = cnt_n;
        state_next.mode = m;
        state_next.busy = !emit;
    end

endmodule

/* sim/binary_field_decoder_tb.sv */
// binary_field_decoder_tb: self-checking bench for the byte-serial field decoder
// drives byte transfers with random idling and stalls, checks each result against
// a behavioral decoder model; depends on bfd_pkg and binary_field_decoder
module binary_field_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bfd_pkg::*;

    localparam int         CYCLE_LIMIT = 200000;
    localparam int         IDLE_PCT    = 12;
    localparam int         REPORT_CAP  = 40;
    localparam logic [3:0] MODE_SPARE  = 4'hF;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_data_byte;
    logic [3:0]  s_mode;
    logic        s_buffer_end;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_value;
    logic        m_status;
    logic [3:0]  m_bytes_used;

    logic [63:0] acc_model;
    int          cnt_model;
    mode_t       mode_model;
    logic        busy_model;
    dec_result_t pending_results[$];

    int   errors = 0;
    int   cycles = 0;
    int   bytes_sent = 0;
    int   stall_request = 0;
    int   stall_left = 0;
    logic quiet = 1'b0;

    binary_field_decoder dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_mode       (s_mode),
        .s_buffer_end (s_buffer_end),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .m_status     (m_status),
        .m_bytes_used (m_bytes_used)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= REPORT_CAP)
            $display("mismatch at cycle %0d: %s", cycles, msg);
    endtask

    function automatic int fixed_width(input mode_t md);
        case (md)
            MODE_U16:           return 2;
            MODE_U32, MODE_I32: return 4;
            MODE_U64, MODE_I64: return 8;
            default:            return 1;
        endcase
    endfunction

    function automatic void push_result(input logic [63:0] v, input logic st);
        dec_result_t r;
        r.value      = v;
        r.status     = st;
        r.bytes_used = cnt_model[3:0];
        pending_results.push_back(r);
        busy_model = 1'b0;
    endfunction

    function automatic void model_byte(input logic [7:0] b, input logic [3:0] md,
                                       input logic last);
        logic [63:0] v;
        int          sh;
        int          lim;
        logic        is32;
        logic        sgn;
        if (!busy_model) begin
            mode_model = (md > MODE_VI64) ? MODE_U8 : mode_t'(md);
            acc_model  = '0;
            cnt_model  = 0;
            busy_model = 1'b1;
        end
        if (mode_model >= MODE_VU32) begin
            is32 = (mode_model == MODE_VU32) || (mode_model == MODE_VI32);
            sgn  = (mode_model == MODE_VI32) || (mode_model == MODE_VI64);
            lim  = is32 ? LIMIT32 : LIMIT64;
            sh   = 7 * cnt_model;
            if (sh < 64)
                acc_model |= {57'd0, b[6:0]} << sh;
            cnt_model++;
            if (!b[CONT_BIT]) begin
                sh = 7 * cnt_model;
                v  = acc_model;
                if (sgn && sh < 64 && b[SIGN_BIT])
                    v |= ~64'd0 << sh;
                if (is32)
                    v = sgn ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
                push_result(v, 1'b0);
            end else if (cnt_model >= lim || last) begin
                push_result('0, 1'b1);
            end
        end else begin
            acc_model |= {56'd0, b} << ((8 * cnt_model) & 63);
            cnt_model++;
            if (cnt_model >= fixed_width(mode_model)) begin
                v = acc_model;
                if (mode_model == MODE_I8)
                    v = {{56{v[7]}}, v[7:0]};
                else if (mode_model == MODE_I32)
                    v = {{32{v[31]}}, v[31:0]};
                push_result(v, 1'b0);
            end else if (last) begin
                push_result('0, 1'b1);
            end
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        dec_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result value %h", m_value));
            end else begin
                want = pending_results.pop_front();
                if (m_value !== want.value)
                    report_mismatch($sformatf("value %h, expected %h", m_value, want.value));
                if (m_status !== want.status)
                    report_mismatch($sformatf("status %b, expected %b", m_status, want.status));
                if (m_bytes_used !== want.bytes_used)
                    report_mismatch($sformatf("bytes_used %0d, expected %0d",
                                              m_bytes_used, want.bytes_used));
            end
        end
    end

    // result receiver, long holds counted here
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall_request > 0) begin
                stall_left    = stall_request;
                stall_request = 0;
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // one byte transfer, entered and left at a falling edge
    task automatic send_byte(input logic [7:0] b, input logic [3:0] md, input logic last);
        if (!quiet && $urandom_range(99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
            while ($urandom_range(99) < 25)
                @(negedge aclk);
        end
        model_byte(b, md, last);
        s_valid      <= 1'b1;
        s_data_byte  <= b;
        s_mode       <= md;
        s_buffer_end <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        bytes_sent++;
        @(negedge aclk);
    endtask

    // bytes packed low byte first; buffer_end raised at end_at, which also stops the value
    task automatic send_value(input logic [3:0] md, input logic [79:0] bytes, input int len,
                              input int end_at);
        for (int i = 0; i < len; i++) begin
            send_byte(bytes[8*i +: 8], (i == 0) ? md : 4'($urandom), i == end_at);
            if (i == end_at)
                break;
        end
    endtask

    task automatic send_random_value();
        int          kind;
        int          len;
        int          lim;
        int          pick;
        int          end_at;
        logic [3:0]  md;
        logic [79:0] bytes;
        // close any value left open by noise
        if (busy_model)
            send_byte(8'($urandom), 4'($urandom), 1'b1);
        kind = $urandom_range(99);
        if (kind < 8) begin
            len = $urandom_range(1, 6);
            for (int i = 0; i < len; i++)
                send_byte(8'($urandom), 4'($urandom), $urandom_range(4) == 0);
        end else begin
            if (kind < 13)
                md = 4'($urandom_range(MODE_VI64 + 1, MODE_SPARE));
            else
                md = 4'($urandom_range(MODE_U8, MODE_VI64));
            for (int i = 0; i < 10; i++) begin
                case ($urandom_range(9))
                    0:       bytes[8*i +: 8] = 8'h00;
                    1:       bytes[8*i +: 8] = 8'hFF;
                    2:       bytes[8*i +: 8] = 8'h7F;
                    3:       bytes[8*i +: 8] = 8'h80;
                    default: bytes[8*i +: 8] = 8'($urandom);
                endcase
            end
            if (md >= MODE_VU32 && md <= MODE_VI64) begin
                lim = (md == MODE_VU32 || md == MODE_VI32) ? LIMIT32 : LIMIT64;
                len = ($urandom_range(3) == 0) ? lim : $urandom_range(1, lim);
                for (int i = 0; i < len; i++)
                    bytes[8*i + CONT_BIT] = (i < len - 1);
                // varint running past its limit
                if ($urandom_range(7) == 0) begin
                    len = lim;
                    for (int i = 0; i < len; i++)
                        bytes[8*i + CONT_BIT] = 1'b1;
                end
            end else begin
                len = fixed_width(mode_t'(md));
            end
            pick = $urandom_range(99);
            if (pick < 10)
                end_at = $urandom_range(0, len - 1);
            else if (pick < 40)
                end_at = len - 1;
            else
                end_at = -1;
            send_value(md, bytes, len, end_at);
        end
    endtask

    task automatic send_random_bytes(input int count);
        int stop_at;
        stop_at = bytes_sent + count;
        while (bytes_sent < stop_at)
            send_random_value();
    endtask

    task automatic test_fixed_directed();
        send_value(MODE_U8, 80'hFF, 1, -1);
        send_value(MODE_SPARE, 80'h80, 1, -1);
        send_value(MODE_I8, 80'h80, 1, -1);
        send_value(MODE_U16, 80'hFF00, 2, 1);
        send_value(MODE_I32, 80'h8000_0000, 4, -1);
    endtask

    task automatic test_varint_directed();
        send_value(MODE_VI32, 80'h40, 1, -1);
        send_value(MODE_VU32, 80'h7F_FFFF_FFFF, 5, -1);
        send_value(MODE_VU32, 80'h80_8080_8080, 5, -1);
        send_value(MODE_VU64, 80'h00, 1, -1);
    endtask

    task automatic test_early_end();
        send_value(MODE_U64, 80'hA5, 1, 0);
        send_value(MODE_I64, 80'hFF01, 2, 1);
        send_value(MODE_U32, 80'h7F, 1, 0);
        send_value(MODE_VI64, 80'h80, 1, 0);
    endtask

    task automatic test_random_traffic();
        send_random_bytes(550);
    endtask

    task automatic test_backpressure();
        stall_request = 300;
        send_random_bytes(150);
    endtask

    task automatic test_no_idle();
        quiet = 1'b1;
        send_random_bytes(450);
        quiet = 1'b0;
    endtask

    initial begin
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_data_byte  = '0;
        s_mode       = '0;
        s_buffer_end = 1'b0;
        acc_model    = '0;
        cnt_model    = 0;
        mode_model   = MODE_U8;
        busy_model   = 1'b0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_fixed_directed();
        test_varint_directed();
        test_early_end();
        test_random_traffic();
        test_backpressure();
        test_no_idle();
        test_random_traffic();

        s_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
